// File: rtl/transposition_table_engine_macros.svh
// Assertion macros used by the top-level design file.
`ifndef TRANSPOSITION_TABLE_ENGINE_MACROS_SVH
`define TRANSPOSITION_TABLE_ENGINE_MACROS_SVH

// A check that is skipped while reset is held.
`define TTE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A check that also holds during reset.
`define TTE_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tte_pkg.sv
`timescale 1ns / 1ps

package tte_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_INDEX_BITS = 16;
	localparam int DEF_WAYS = 3;
	localparam int DEF_FILL_SAMPLE_BUCKETS = 333;

	// Stream widths; the data widths are padded to whole bytes.
	localparam int IN_DATA_W = 136;
	localparam int IN_USER_W = 3;
	localparam int OUT_DATA_W = 72;

	localparam int TAG_LSB = 48;
	localparam int PERMILLE = 1000;

	// Command codes.
	localparam logic [2:0] CMD_PROBE = 3'd0;
	localparam logic [2:0] CMD_STORE = 3'd1;
	localparam logic [2:0] CMD_NEW_SEARCH = 3'd2;
	localparam logic [2:0] CMD_CLEAR = 3'd3;
	localparam logic [2:0] CMD_FILL = 3'd4;
	localparam logic [2:0] CMD_NONE = 3'd7;

	// Configuration register indexes.
	localparam logic [3:0] REG_INDEX_BITS = 4'd0;
	localparam logic [3:0] REG_MATE_BOUND = 4'd1;

	localparam logic [4:0] RST_INDEX_BITS = 5'd16;
	localparam logic [14:0] RST_MATE_BOUND = 15'd31754;

	// One stored entry; flag holds the generation above the bound.
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] move_code;
		logic [7:0]  depth;
		logic [7:0]  flag;
		logic [15:0] eval;
		logic [15:0] value;
	} entry_t;

	// One classified command in the queue.
	typedef struct packed {
		logic [2:0]  op;
		logic        way_ok;
		logic [63:0] key;
		logic [1:0]  way;
		logic [15:0] move_code;
		logic [7:0]  depth;
		logic [15:0] score;
		logic [15:0] pos_eval;
		logic [1:0]  bound;
		logic [9:0]  ply;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic        hit;
		logic [1:0]  slot_way;
		logic [15:0] found_move;
		logic [7:0]  found_depth;
		logic [15:0] found_score;
		logic [15:0] found_eval;
		logic [1:0]  found_bound;
		logic [9:0]  fill_permille;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
	} fe_status_t;

	typedef struct packed {
		logic clearing;
	} bk_status_t;

	// Saturate a widened score back to 16 bits.
	function automatic logic [15:0] sat16(input logic signed [17:0] v);
		logic [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/tte_front.sv
`timescale 1ns / 1ps

module tte_front import tte_pkg::*; #(
	parameter int WAYS = DEF_WAYS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [IN_USER_W-1:0] s_tuser,
	input  logic                 hold,
	output logic                 q_valid,
	output item_t                q_item,
	input  logic                 q_pop,
	output fe_status_t           status
);

	item_t       slot_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	item_t       item_in;
	logic        push;
	logic        pop;

	// Unpack the beat and classify the command.
	always_comb begin
		item_in.key = s_tdata[63:0];
		item_in.way = s_tdata[65:64];
		item_in.move_code = s_tdata[81:66];
		item_in.depth = s_tdata[89:82];
		item_in.score = s_tdata[105:90];
		item_in.pos_eval = s_tdata[121:106];
		item_in.bound = s_tdata[123:122];
		item_in.ply = s_tdata[133:124];
		item_in.way_ok = (int'(s_tdata[65:64]) < WAYS);
		case (s_tuser) inside
			CMD_PROBE, CMD_STORE, CMD_NEW_SEARCH, CMD_CLEAR, CMD_FILL: item_in.op = s_tuser;
			default: item_in.op = CMD_NONE;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2) && !hold;
	assign push = s_tvalid && s_tready;
	assign pop = q_pop && q_valid;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = slot_q[rp_q];
	assign status.count = cnt_q;

	// Two-entry queue between the front and the back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= item_in;
		end
	end

endmodule

// File: rtl/tte_div.sv
`timescale 1ns / 1ps

module tte_div import tte_pkg::*; #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign fits = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo = quo_q;

endmodule

// File: rtl/tte_back.sv
`timescale 1ns / 1ps

module tte_back import tte_pkg::*; #(
	parameter int INDEX_BITS = DEF_INDEX_BITS,
	parameter int WAYS = DEF_WAYS,
	parameter int FILL_SAMPLE_BUCKETS = DEF_FILL_SAMPLE_BUCKETS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4:0]  index_bits,
	input  logic [14:0] mate_bound,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	input  logic        out_ready,
	output logic        out_valid,
	output result_t     out_data,
	output bk_status_t  status
);

	localparam int NBUCKETS = 1 << INDEX_BITS;
	localparam int WAY_W = $clog2(WAYS);
	localparam int SAMP_MAX = (FILL_SAMPLE_BUCKETS < NBUCKETS) ? FILL_SAMPLE_BUCKETS : NBUCKETS;
	localparam int WALK_W = $clog2(SAMP_MAX + 1);
	localparam int CNT_W = $clog2(SAMP_MAX * WAYS + 1);
	localparam int DEN_W = CNT_W;
	localparam int NUM_W = CNT_W + 10;
	localparam int POP_W = $clog2(WAYS + 1);

	localparam logic [3:0] ST_CLR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_PICK = 4'd2;
	localparam logic [3:0] ST_FIN = 4'd3;
	localparam logic [3:0] ST_WR = 4'd4;
	localparam logic [3:0] ST_MISC = 4'd5;
	localparam logic [3:0] ST_FILL = 4'd6;
	localparam logic [3:0] ST_MUL = 4'd7;
	localparam logic [3:0] ST_DSTART = 4'd8;
	localparam logic [3:0] ST_DIV = 4'd9;

	typedef entry_t [WAYS-1:0] row_t;

	row_t                  mem [NBUCKETS];
	row_t                  rd_row_q;
	logic [INDEX_BITS-1:0] raddr;
	logic [INDEX_BITS-1:0] waddr;
	row_t                  wdata;
	logic                  we;

	logic [3:0]            state_q;
	item_t                 cur_q;
	logic [5:0]            gen_q;
	logic [INDEX_BITS:0]   clr_q;
	logic                  clr_emit_q;
	logic [WALK_W-1:0]     walk_q;
	logic [WALK_W-1:0]     n_q;
	logic                  rdv_s1;
	logic [CNT_W-1:0]      cnt_q;
	logic [NUM_W-1:0]      num_q;
	logic [DEN_W-1:0]      den_q;
	logic                  hit_q;
	logic [WAY_W-1:0]      pick_q;
	entry_t                ent_q;
	logic                  res_valid_q;
	result_t               res_q;

	logic [4:0]            b_eff;
	logic [INDEX_BITS-1:0] idx_mask;
	logic [INDEX_BITS-1:0] head_bucket;
	logic [INDEX_BITS-1:0] cur_bucket;
	logic [INDEX_BITS:0]   inuse;
	logic [WALK_W-1:0]     n_samp;
	logic                  out_free;
	logic                  emit;
	result_t               res_d;
	logic                  found;
	logic                  hit_c;
	logic [WAY_W-1:0]      pick_c;
	logic signed [11:0]    rank [WAYS];
	logic signed [11:0]    best_rank;
	logic [POP_W-1:0]      row_pop;
	logic signed [16:0]    mb17;
	logic signed [16:0]    pv17;
	logic [15:0]           probe_score;
	logic signed [16:0]    sv17;
	logic [15:0]           store_score;
	entry_t                old_ent;
	entry_t                new_ent;
	logic                  newtag;
	logic                  deeper;
	logic                  div_start;
	logic                  div_busy;
	logic [NUM_W-1:0]      div_quo;

	// Effective index width and bucket addresses.
	always_comb begin
		b_eff = (index_bits > 5'(INDEX_BITS)) ? 5'(INDEX_BITS) : index_bits;
		for (int i = 0; i < INDEX_BITS; i++) begin
			idx_mask[i] = (5'(i) < b_eff);
		end
		head_bucket = q_item.key[INDEX_BITS-1:0] & idx_mask;
		cur_bucket = cur_q.key[INDEX_BITS-1:0] & idx_mask;
		inuse = (INDEX_BITS + 1)'(1) << b_eff;
		if (32'(inuse) > 32'(FILL_SAMPLE_BUCKETS)) begin
			n_samp = WALK_W'(FILL_SAMPLE_BUCKETS);
		end else begin
			n_samp = WALK_W'(inuse);
		end
	end

	// Read address follows the state.
	always_comb begin
		case (state_q)
			ST_IDLE: raddr = head_bucket;
			ST_FILL: raddr = INDEX_BITS'(walk_q);
			default: raddr = cur_bucket;
		endcase
	end

	// Bucket memory: one row a cycle, registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_row_q <= mem[raddr];
	end

	// Probe: first matching or empty way, else the lowest rank.
	always_comb begin
		found = 1'b0;
		hit_c = 1'b0;
		pick_c = '0;
		for (int w = 0; w < WAYS; w++) begin
			rank[w] = $signed({{4{rd_row_q[w].depth[7]}}, rd_row_q[w].depth}) -
				$signed({2'b00, 6'(gen_q - rd_row_q[w].flag[7:2]), 4'b0000});
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!found) begin
				if (rd_row_q[w].tag == cur_q.key[63:TAG_LSB]) begin
					pick_c = WAY_W'(w);
					hit_c = 1'b1;
					found = 1'b1;
				end else if (rd_row_q[w].tag == 16'd0) begin
					pick_c = WAY_W'(w);
					found = 1'b1;
				end
			end
		end
		best_rank = rank[0];
		if (!found) begin
			for (int w = 1; w < WAYS; w++) begin
				if (rank[w] < best_rank) begin
					best_rank = rank[w];
					pick_c = WAY_W'(w);
				end
			end
		end
	end

	// Undo the ply shift of a mate score on probe.
	always_comb begin
		mb17 = $signed({2'b00, mate_bound});
		pv17 = $signed({ent_q.value[15], ent_q.value});
		if (pv17 >= mb17) begin
			probe_score = sat16(18'(pv17) - $signed({8'd0, cur_q.ply}));
		end else if (pv17 <= -mb17) begin
			probe_score = sat16(18'(pv17) + $signed({8'd0, cur_q.ply}));
		end else begin
			probe_score = ent_q.value;
		end
	end

	// Store: apply the ply shift and the replacement rule.
	always_comb begin
		sv17 = $signed({cur_q.score[15], cur_q.score});
		if (sv17 >= mb17) begin
			store_score = sat16(18'(sv17) + $signed({8'd0, cur_q.ply}));
		end else if (sv17 <= -mb17) begin
			store_score = sat16(18'(sv17) - $signed({8'd0, cur_q.ply}));
		end else begin
			store_score = cur_q.score;
		end
		old_ent = rd_row_q[WAY_W'(cur_q.way)];
		newtag = (old_ent.tag != cur_q.key[63:TAG_LSB]);
		deeper = $signed({cur_q.depth[7], cur_q.depth}) >
			($signed({old_ent.depth[7], old_ent.depth}) - 9'sd4);
		new_ent = old_ent;
		if (cur_q.move_code != 16'd0 || newtag) begin
			new_ent.move_code = cur_q.move_code;
		end
		if (newtag || deeper) begin
			new_ent.tag = cur_q.key[63:TAG_LSB];
			new_ent.depth = cur_q.depth;
			new_ent.flag = {gen_q, cur_q.bound};
			new_ent.eval = cur_q.pos_eval;
			new_ent.value = store_score;
		end
	end

	// Current-generation entries in the row under the fill walk.
	always_comb begin
		row_pop = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (rd_row_q[w].tag != 16'd0 && rd_row_q[w].flag[7:2] == gen_q) begin
				row_pop = row_pop + 1'b1;
			end
		end
	end

	// Write port: clearing sweep or store write-back.
	always_comb begin
		we = 1'b0;
		waddr = cur_bucket;
		wdata = rd_row_q;
		if (state_q == ST_CLR) begin
			we = !clr_q[INDEX_BITS];
			waddr = clr_q[INDEX_BITS-1:0];
			wdata = '0;
		end else if (state_q == ST_WR) begin
			we = out_free && cur_q.way_ok;
			wdata[WAY_W'(cur_q.way)] = new_ent;
		end
	end

	assign out_free = !res_valid_q || out_ready;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign div_start = (state_q == ST_DSTART);
	assign status.clearing = (state_q == ST_CLR);

	// A result beat is loaded into the output register in this cycle.
	assign emit = out_free && ((state_q == ST_FIN) || (state_q == ST_WR) ||
		(state_q == ST_MISC) || (state_q == ST_DIV && !div_busy));

	// Result beat contents for the command that finishes.
	always_comb begin
		res_d = '0;
		case (state_q)
			ST_FIN: begin
				res_d.hit = hit_q;
				res_d.slot_way = 2'(pick_q);
				res_d.found_move = ent_q.move_code;
				res_d.found_depth = ent_q.depth;
				res_d.found_score = probe_score;
				res_d.found_eval = ent_q.eval;
				res_d.found_bound = ent_q.flag[1:0];
			end
			ST_WR: res_d.slot_way = cur_q.way;
			ST_DIV: res_d.fill_permille = div_quo[9:0];
			default: ;
		endcase
	end

	tte_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num_q),
		.den(den_q),
		.busy(div_busy),
		.quo(div_quo)
	);

	// Sequencer for the back part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			clr_emit_q <= 1'b0;
			gen_q <= '0;
			walk_q <= '0;
			rdv_s1 <= 1'b0;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					if (clr_q[INDEX_BITS]) begin
						state_q <= clr_emit_q ? ST_MISC : ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						case (q_item.op)
							CMD_PROBE: state_q <= ST_PICK;
							CMD_STORE: state_q <= ST_WR;
							CMD_CLEAR: begin
								clr_q <= '0;
								clr_emit_q <= 1'b1;
								gen_q <= '0;
								state_q <= ST_CLR;
							end
							CMD_FILL: begin
								walk_q <= '0;
								rdv_s1 <= 1'b0;
								cnt_q <= '0;
								state_q <= ST_FILL;
							end
							default: state_q <= ST_MISC;
						endcase
					end
				end
				ST_PICK: state_q <= ST_FIN;
				ST_FIN, ST_WR, ST_MISC: begin
					if (out_free) begin
						if (cur_q.op == CMD_NEW_SEARCH) begin
							gen_q <= gen_q + 6'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FILL: begin
					rdv_s1 <= (walk_q != n_q);
					if (walk_q != n_q) begin
						walk_q <= walk_q + 1'b1;
					end
					if (rdv_s1) begin
						cnt_q <= cnt_q + CNT_W'(row_pop);
					end
					if (walk_q == n_q && !rdv_s1) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DIV;
				ST_DIV: begin
					if (!div_busy && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			cur_q <= q_item;
			n_q <= n_samp;
		end
		if (state_q == ST_PICK) begin
			hit_q <= hit_c;
			pick_q <= pick_c;
			ent_q <= rd_row_q[pick_c];
		end
		if (state_q == ST_MUL) begin
			num_q <= NUM_W'(cnt_q) * NUM_W'(PERMILLE);
			den_q <= DEN_W'(n_q * WAYS);
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data = res_q;

endmodule

// File: rtl/transposition_table_engine.sv
`timescale 1ns / 1ps
// Transposition table engine.
// Commands enter on the s_ channel (tuser holds the command, tdata the key and
// store data); every command gives exactly one result beat on the m_ channel.
// Registers are written on the cfg_ channel, which is always ready.
// A two-entry queue sits between the input and the executing back part, so
// inputs are taken while a result waits for the receiver.
// From the queue head a probe passes the pick and finish states, a store the
// write state, and new search and unknown commands the misc state; one
// command is executed at a time, and a probe waits in the pick state for the
// registered read of the bucket memory row.
// A fill query walks one bucket row a cycle over the sampled buckets and then
// runs a serial divider.
// After reset and on each clear command the memory is zeroed one row a cycle,
// all 2^INDEX_BITS rows; s_tready is low during that pass.
// When m_tready is low the result holds in its output register and the back
// part waits before producing the next one.

module transposition_table_engine import tte_pkg::*; #(
	parameter int INDEX_BITS = DEF_INDEX_BITS,
	parameter int WAYS = DEF_WAYS,
	parameter int FILL_SAMPLE_BUCKETS = DEF_FILL_SAMPLE_BUCKETS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// key[63:0], way[65:64], move_code[81:66], depth[89:82], score[105:90],
	// pos_eval[121:106], bound[123:122], ply[133:124], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd[2:0]
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// hit[0], slot_way[2:1], found_move[18:3], found_depth[26:19],
	// found_score[42:27], found_eval[58:43], found_bound[60:59],
	// fill_permille[70:61], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [3:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	logic [4:0]  index_bits_q;
	logic [14:0] mate_bound_q;
	logic        q_valid;
	item_t       q_item;
	logic        q_pop;
	result_t     res;
	fe_status_t  fe_status;
	bk_status_t  bk_status;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= RST_INDEX_BITS;
			mate_bound_q <= RST_MATE_BOUND;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INDEX_BITS: index_bits_q <= cfg_data[4:0];
				REG_MATE_BOUND: mate_bound_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	tte_front #(
		.WAYS(WAYS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.hold(bk_status.clearing),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.status(fe_status)
	);

	tte_back #(
		.INDEX_BITS(INDEX_BITS),
		.WAYS(WAYS),
		.FILL_SAMPLE_BUCKETS(FILL_SAMPLE_BUCKETS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.index_bits(index_bits_q),
		.mate_bound(mate_bound_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data(res),
		.status(bk_status)
	);

	// Result beat packing.
	assign m_tdata = {1'b0, res.fill_permille, res.found_bound, res.found_eval,
		res.found_score, res.found_depth, res.found_move, res.slot_way, res.hit};

`include "transposition_table_engine_macros.svh"

	`TTE_ASSERT_ALWAYS(a_no_input_while_clearing, bk_status.clearing |-> !s_tready, "input taken during clearing pass")
	`TTE_ASSERT(a_queue_bound, fe_status.count != 2'd3, "queue count out of range")
	`TTE_ASSERT(a_fill_range, m_tvalid |-> (m_tdata[70:61] <= 10'(PERMILLE)), "fill share above 1000")
	`TTE_ASSERT(a_hit_way, (m_tvalid && m_tdata[0]) |-> (int'(m_tdata[2:1]) < WAYS), "hit on a way out of range")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tte_pkg::*;

	// Predicts the table contents and the result of every command, and
	// holds the results that are still owed by the block.
	class tt_scoreboard;
		entry_t slots[int];
		int unsigned gen;
		logic [4:0] idx_bits;
		logic [14:0] mate_lim;
		result_t owed[$];
		int errors;

		function new();
			wipe();
			idx_bits = RST_INDEX_BITS;
			mate_lim = RST_MATE_BOUND;
			errors = 0;
		endfunction

		function void wipe();
			slots.delete();
			gen = 0;
		endfunction

		function void set_reg(logic [3:0] idx, logic [15:0] data);
			if (idx == REG_INDEX_BITS) begin
				idx_bits = data[4:0];
			end else if (idx == REG_MATE_BOUND) begin
				mate_lim = data[14:0];
			end
		endfunction

		function int used_bits();
			return (idx_bits > DEF_INDEX_BITS) ? DEF_INDEX_BITS : int'(idx_bits);
		endfunction

		function int bucket(logic [63:0] key);
			return int'(key & ((64'd1 << used_bits()) - 64'd1));
		endfunction

		function entry_t read(int e);
			if (slots.exists(e)) begin
				return slots[e];
			end
			return '0;
		endfunction

		function int rank(int e);
			entry_t x;
			int age;
			x = read(e);
			age = (gen - x.flag[7:2]) & 63;
			return int'($signed(x.depth)) - age * 16;
		endfunction

		function int sat(int v);
			if (v > 32767) begin
				return 32767;
			end else if (v < -32768) begin
				return -32768;
			end
			return v;
		endfunction

		// Way a probe of this key lands on: first matching or empty way, else oldest/shallowest.
		function int choose_way(logic [63:0] key, output bit hit);
			int base;
			base = bucket(key) * DEF_WAYS;
			hit = 0;
			for (int w = 0; w < DEF_WAYS; w++) begin
				if (read(base + w).tag == key[63:48]) begin
					hit = 1;
					return w;
				end else if (read(base + w).tag == 16'd0) begin
					return w;
				end
			end
			choose_way = 0;
			for (int w = 1; w < DEF_WAYS; w++) begin
				if (rank(base + w) < rank(base + choose_way)) begin
					choose_way = w;
				end
			end
		endfunction

		function void note(item_t it);
			result_t r;
			entry_t x;
			bit hit, newtag;
			int w, e, v, mb, ply, n, cnt;
			r = '0;
			mb = int'(mate_lim);
			ply = int'(it.ply);
			case (it.op)
				CMD_PROBE: begin
					w = choose_way(it.key, hit);
					x = read(bucket(it.key) * DEF_WAYS + w);
					v = int'($signed(x.value));
					if (v >= mb) begin
						v = sat(v - ply);
					end else if (v <= -mb) begin
						v = sat(v + ply);
					end
					r.hit = hit;
					r.slot_way = w[1:0];
					r.found_move = x.move_code;
					r.found_depth = x.depth;
					r.found_score = v[15:0];
					r.found_eval = x.eval;
					r.found_bound = x.flag[1:0];
				end
				CMD_STORE: begin
					r.slot_way = it.way;
					if (it.way < DEF_WAYS) begin
						e = bucket(it.key) * DEF_WAYS + it.way;
						x = read(e);
						newtag = x.tag != it.key[63:48];
						v = int'($signed(it.score));
						if (v >= mb) begin
							v = sat(v + ply);
						end else if (v <= -mb) begin
							v = sat(v - ply);
						end
						if (it.move_code != 16'd0 || newtag) begin
							x.move_code = it.move_code;
						end
						if (newtag || int'($signed(it.depth)) > int'($signed(x.depth)) - 4) begin
							x.tag = it.key[63:48];
							x.depth = it.depth;
							x.flag = {gen[5:0], it.bound};
							x.eval = it.pos_eval;
							x.value = v[15:0];
						end
						slots[e] = x;
					end
				end
				CMD_NEW_SEARCH: gen = (gen + 1) & 63;
				CMD_CLEAR: wipe();
				CMD_FILL: begin
					n = 1 << used_bits();
					if (n > DEF_FILL_SAMPLE_BUCKETS) begin
						n = DEF_FILL_SAMPLE_BUCKETS;
					end
					cnt = 0;
					foreach (slots[k]) begin
						if (k < n * DEF_WAYS && slots[k].tag != 16'd0 && slots[k].flag[7:2] == gen) begin
							cnt++;
						end
					end
					r.fill_permille = 10'((cnt * 1000) / (n * DEF_WAYS));
				end
				default: ;
			endcase
			owed.push_back(r);
		endfunction

		function void check(logic [OUT_DATA_W-1:0] d);
			result_t got, exp;
			got.hit = d[0];
			got.slot_way = d[2:1];
			got.found_move = d[18:3];
			got.found_depth = d[26:19];
			got.found_score = d[42:27];
			got.found_eval = d[58:43];
			got.found_bound = d[60:59];
			got.fill_permille = d[70:61];
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result beat %h", d);
				end
				return;
			end
			exp = owed.pop_front();
			if (got.hit !== exp.hit || got.slot_way !== exp.slot_way
					|| got.found_move !== exp.found_move || got.found_depth !== exp.found_depth
					|| got.found_score !== exp.found_score || got.found_eval !== exp.found_eval
					|| got.found_bound !== exp.found_bound
					|| got.fill_permille !== exp.fill_permille) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: expected hit %0d way %0d move %h depth %h score %h eval %h bound %0d fill %0d",
						exp.hit, exp.slot_way, exp.found_move, exp.found_depth, exp.found_score,
						exp.found_eval, exp.found_bound, exp.fill_permille);
					$display("          actual   hit %0d way %0d move %h depth %h score %h eval %h bound %0d fill %0d",
						got.hit, got.slot_way, got.found_move, got.found_depth, got.found_score,
						got.found_eval, got.found_bound, got.fill_permille);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [IN_USER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [3:0] cfg_index;
	logic [15:0] cfg_data;

	tt_scoreboard table_sb;
	bit tx_gaps;
	bit rx_gaps;
	bit hold_req;
	bit clear_sent;
	int unsigned cycles = 0;

	transposition_table_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 3000000) begin
			$display("transposition_table_engine verification failed");
			$finish;
		end
	end

	// Result side: checks each beat and applies random or long stalls.
	initial begin : result_side
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				table_sb.check(m_tdata);
			end
			if (hold_req) begin
				hold_req = 0;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push(item_t it);
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {2'b00, it.ply, it.bound, it.pos_eval, it.score, it.depth,
			it.move_code, it.way, it.key};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		table_sb.note(it);
		if (it.op == CMD_CLEAR) begin
			clear_sent = 1;
		end
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Lets every owed result arrive, then the block settle (a clear walks the whole table).
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (table_sb.owed.size() != 0) begin
			@(posedge clk);
		end
		repeat (clear_sent ? 70000 : 600) @(posedge clk);
		clear_sent = 0;
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		table_sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_key();
		logic [15:0] tag;
		logic [15:0] low;
		case ($urandom_range(0, 7))
			0: tag = 16'h0000;
			1: tag = 16'hFFFF;
			2, 3, 4, 5: tag = 16'($urandom_range(1, 5));
			default: tag = 16'($urandom);
		endcase
		low = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 5)) : 16'($urandom);
		return {tag, 32'($urandom), low};
	endfunction

	function automatic item_t rand_item(logic [2:0] op);
		item_t it;
		int mb;
		it = '0;
		it.op = op;
		it.key = rand_key();
		it.way = 2'($urandom_range(0, 3));
		it.move_code = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
		it.depth = 8'($urandom);
		mb = int'(table_sb.mate_lim);
		if ($urandom_range(0, 2) == 0) begin
			mb = mb + $urandom_range(0, 40) - 20;
			it.score = ($urandom_range(0, 1) != 0) ? 16'(mb) : 16'(-mb);
		end else begin
			it.score = 16'($urandom);
		end
		it.pos_eval = 16'($urandom);
		it.bound = 2'($urandom);
		it.ply = 10'($urandom);
		return it;
	endfunction

	// Probe a key, then store into the way that probe reported.
	task automatic probe_then_store();
		item_t p;
		item_t s;
		bit hit;
		p = rand_item(CMD_PROBE);
		push(p);
		s = rand_item(CMD_STORE);
		s.key = p.key;
		s.way = 2'(table_sb.choose_way(p.key, hit));
		push(s);
	endtask

	task automatic random_phase(int count, bit allow_clear);
		item_t it;
		int k;
		int r;
		k = 0;
		while (k < count) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				probe_then_store();
				k += 2;
			end else begin
				if (r < 60) begin
					it = rand_item(CMD_PROBE);
				end else if (r < 72) begin
					it = rand_item(CMD_STORE);
				end else if (r < 80) begin
					it = rand_item(CMD_NEW_SEARCH);
				end else if (r < 86) begin
					it = rand_item(CMD_FILL);
				end else if (r < 89) begin
					it = rand_item(3'($urandom_range(5, 7)));
				end else if (allow_clear && r == 99 && !clear_sent) begin
					it = rand_item(CMD_CLEAR);
				end else begin
					it = rand_item(CMD_PROBE);
				end
				push(it);
				k++;
			end
		end
	endtask

	initial begin : stimulus
		item_t it;
		table_sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_NONE;
		cfg_valid = 1'b0;
		cfg_index = REG_INDEX_BITS;
		cfg_data = '0;
		tx_gaps = 0;
		rx_gaps = 0;
		hold_req = 0;
		clear_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty probes, extremes, rejected stores, replacement and fill.
		it = '0;
		it.op = CMD_PROBE;
		it.key = 64'h0000_1234_5678_0003;
		push(it);
		it.op = CMD_STORE;
		it.key = 64'hFFFF_0000_0000_0001;
		it.way = 2'd0;
		it.move_code = 16'hFFFF;
		it.depth = 8'sd127;
		it.score = 16'h7FFF;
		it.pos_eval = 16'h7FFF;
		it.bound = 2'd3;
		it.ply = 10'd1023;
		push(it);
		it.way = 2'd3;
		push(it);
		it.key = 64'h0001_0000_0000_0001;
		it.way = 2'd1;
		it.move_code = 16'd0;
		it.depth = 8'h80;
		it.score = 16'h8000;
		it.pos_eval = 16'h8000;
		push(it);
		it.key = 64'h0002_0000_0000_0001;
		it.way = 2'd2;
		it.depth = 8'd5;
		it.score = 16'd31754;
		it.ply = 10'd10;
		push(it);
		it.op = CMD_PROBE;
		push(it);
		it.key = 64'hFFFF_0000_0000_0001;
		push(it);
		it.key = 64'h0001_0000_0000_0001;
		push(it);
		// Same tag, shallower by more than four: kept; zero move keeps the old move.
		it.op = CMD_STORE;
		it.key = 64'hFFFF_0000_0000_0001;
		it.way = 2'd0;
		it.depth = 8'd100;
		it.move_code = 16'd0;
		push(it);
		it.depth = 8'd126;
		push(it);
		it.op = CMD_NEW_SEARCH;
		push(it);
		push(it);
		it.op = CMD_PROBE;
		it.key = 64'h0003_0000_0000_0001;
		push(it);
		it.op = CMD_FILL;
		push(it);
		it.op = CMD_NONE;
		push(it);
		it.op = 3'd5;
		push(it);
		it.op = CMD_PROBE;
		it.key = 64'h0000_0000_0000_0001;
		push(it);
		drain();

		// Small table, every score a mate score; long result-side hold fills the queue.
		write_reg(REG_INDEX_BITS, 16'd4);
		write_reg(REG_MATE_BOUND, 16'd0);
		tx_gaps = 1;
		rx_gaps = 1;
		hold_req = 1;
		random_phase(350, 0);
		drain();

		// Index wider than the table, largest mate bound, with a clear inside.
		write_reg(REG_INDEX_BITS, 16'd31);
		write_reg(REG_MATE_BOUND, 16'h7FFF);
		random_phase(350, 1);
		it = rand_item(CMD_CLEAR);
		push(it);
		random_phase(40, 0);
		drain();

		// Single bucket, small mate bound, no gaps on either side.
		write_reg(REG_INDEX_BITS, 16'd0);
		write_reg(REG_MATE_BOUND, 16'd100);
		tx_gaps = 0;
		rx_gaps = 0;
		random_phase(300, 0);
		drain();

		// Back to the reset settings; the final stretch runs without gaps.
		write_reg(REG_INDEX_BITS, 16'd16);
		write_reg(REG_MATE_BOUND, 16'd31754);
		tx_gaps = 1;
		rx_gaps = 1;
		random_phase(200, 0);
		tx_gaps = 0;
		rx_gaps = 0;
		random_phase(200, 0);
		drain();

		if (table_sb.errors == 0) begin
			$display("transposition_table_engine verification clean");
		end else begin
			$display("transposition_table_engine verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/tte_pkg.sv
rtl/tte_front.sv
rtl/tte_div.sv
rtl/tte_back.sv
rtl/transposition_table_engine.sv
test/testbench.sv
